### design/gmb_pkg.sv
package gmb_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int ACC_BITS     = 48;
    localparam int COEF_BITS    = 16;
    localparam int COEF_FRAC    = 14;
    localparam int BIN_BITS     = 2;
    localparam int MAX_BINS     = 4;
    localparam int CFG_IDX_BITS = 3;

    // Register map: cosine words first, then sine words
    localparam logic [CFG_IDX_BITS-1:0] CFG_COS_BASE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIN_BASE = 3'd4;

    // Intermediate width: holds rounded product plus sample minus delay exactly
    localparam int WIDE_BITS = ACC_BITS + COEF_BITS + 3;

    typedef logic signed [SAMPLE_BITS-1:0]       sample_t;
    typedef logic signed [COEF_BITS-1:0]         coef_t;
    typedef logic signed [ACC_BITS-1:0]          acc_t;
    typedef logic signed [WIDE_BITS-1:0]         wide_t;
    typedef logic signed [ACC_BITS+COEF_BITS-1:0] mul_t;
    typedef logic signed [ACC_BITS+COEF_BITS:0]   mul2_t;

    localparam acc_t  ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam acc_t  ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam wide_t RND_HALF = wide_t'(2**(COEF_FRAC-1));

    // Input transfer payload
    typedef struct packed {
        sample_t sample;
        logic    block_end;
    } gmb_in_t;

    // Result transfer payload
    typedef struct packed {
        logic [BIN_BITS-1:0] bin_index;
        acc_t                real_value;
        acc_t                imag_value;
        logic                last_bin;
    } gmb_out_t;

    // One bin result held in a cell's output slot
    typedef struct packed {
        acc_t real_value;
        acc_t imag_value;
    } gmb_res_t;

    typedef struct packed {
        logic     valid;
        gmb_res_t res;
    } gmb_slot_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic step;       // input transfer this cycle
        logic block_end;  // that sample closes the block
        logic load;       // snapshot moves into the result slots
        logic shift;      // result slots advance toward bin 0
    } gmb_ctrl_t;

    // Round half up, then drop the fraction bits
    function automatic wide_t rnd_shift(wide_t v);
        wide_t t;
        t = v + RND_HALF;
        return t >>> COEF_FRAC;
    endfunction

    // Clamp to the accumulator range
    function automatic acc_t sat_acc(wide_t v);
        acc_t r;
        if (v > wide_t'(ACC_MAX))
            r = ACC_MAX;
        else if (v < wide_t'(ACC_MIN))
            r = ACC_MIN;
        else
            r = acc_t'(v);
        return r;
    endfunction

endpackage

### design/gmb_cell.sv
module gmb_cell
    import gmb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  gmb_ctrl_t ctrl,
    input  coef_t     cos_coef,
    input  coef_t     sin_coef,
    input  sample_t   sample,
    input  gmb_slot_t nbr,
    output gmb_slot_t slot
);

    acc_t     s1_reg, s1_next;
    acc_t     s2_reg, s2_next;
    acc_t     snap_s1_reg;
    acc_t     snap_s2_reg;
    logic     slot_valid_reg, slot_valid_next;
    gmb_res_t slot_res_reg, slot_res_next;

    logic signed [COEF_BITS:0] coef2;
    mul2_t    mul_rec;
    mul_t     mul_re;
    mul_t     mul_im;
    wide_t    s0_wide;
    wide_t    re_wide;
    wide_t    im_wide;
    acc_t     s0;
    gmb_res_t res_new;

    // Recursion: s0 = x + rnd(2cos * s1) - s2
    assign coef2   = {cos_coef, 1'b0};
    assign mul_rec = s1_reg * coef2;
    assign s0_wide = rnd_shift(wide_t'(mul_rec)) + wide_t'(sample) - wide_t'(s2_reg);
    assign s0      = sat_acc(s0_wide);

    // Final bin value from the snapshot of the closing state
    assign mul_re  = snap_s1_reg * cos_coef;
    assign mul_im  = snap_s1_reg * sin_coef;
    assign re_wide = rnd_shift(wide_t'(mul_re)) - wide_t'(snap_s2_reg);
    assign im_wide = rnd_shift(wide_t'(mul_im));
    assign res_new.real_value = sat_acc(re_wide);
    assign res_new.imag_value = sat_acc(im_wide);

    // Delay line update; block end clears it
    always_comb
    begin
        s1_next = s1_reg;
        s2_next = s2_reg;
        if (ctrl.step)
        begin
            if (ctrl.block_end)
            begin
                s1_next = '0;
                s2_next = '0;
            end
            else
            begin
                s1_next = s0;
                s2_next = s1_reg;
            end
        end
    end

    // Result slot: load from snapshot, or take the neighbor's result
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_res_next   = slot_res_reg;
        if (ctrl.load)
        begin
            slot_valid_next = 1'b1;
            slot_res_next   = res_new;
        end
        else if (ctrl.shift)
        begin
            slot_valid_next = nbr.valid;
            slot_res_next   = nbr.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg         <= '0;
            s2_reg         <= '0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg         <= s1_next;
            s2_reg         <= s2_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.step && ctrl.block_end)
        begin
            snap_s1_reg <= s0;
            snap_s2_reg <= s1_reg;
        end
        slot_res_reg <= slot_res_next;
    end

    assign slot.valid = slot_valid_reg;
    assign slot.res   = slot_res_reg;

endmodule

### design/goertzel_multi_bin_top.sv
// Channel  Direction  Signals                               Payload
// smp      in         smp_valid / smp_ready / smp_data      gmb_in_t  (sample, block_end)
// res      out        res_valid / res_ready / res_data      gmb_out_t (bin, real, imag, last)
// cfg      in         cfg_valid / cfg_ready / cfg_index     cfg_data  (coef word, Q2.14)
//
// One sample per cycle while smp_ready is high; each bin cell computes its recursion combinationally.
// Block end: the closing state goes to the snapshot registers, then into the result slots
// once they are free; bin 0 leaves first, then one bin per cycle while res_ready is high.
// smp_ready drops only when a finished block's snapshot waits for the result slots
// to drain; NUM_BINS results must leave before the next block end can move up.
// Reset clears the delay lines, the coefficients, and all valid flags; cfg never stalls.
module goertzel_multi_bin_top
    import gmb_pkg::*;
#(
    parameter int NUM_BINS = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    smp_valid,
    output logic                    smp_ready,
    input  gmb_in_t                 smp_data,
    output logic                    res_valid,
    input  logic                    res_ready,
    output gmb_out_t                res_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  coef_t                   cfg_data
);

    coef_t     cos_reg [NUM_BINS];
    coef_t     sin_reg [NUM_BINS];
    logic      snap_valid_reg, snap_valid_next;
    logic [BIN_BITS-1:0] head_reg, head_next;

    gmb_ctrl_t ctrl;
    gmb_slot_t slot [NUM_BINS];
    gmb_slot_t nbr  [NUM_BINS];
    logic [NUM_BINS-1:0] slot_v;
    logic      chain_free;
    logic      cfg_we;

    // Coefficient registers
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                cos_reg[k] <= '0;
                sin_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                if (cfg_index == CFG_COS_BASE + CFG_IDX_BITS'(k))
                    cos_reg[k] <= cfg_data;
                if (cfg_index == CFG_SIN_BASE + CFG_IDX_BITS'(k))
                    sin_reg[k] <= cfg_data;
            end
        end
    end

    // Slot valids fill together and drain from bin 0, so they form a prefix
    always_comb
    begin
        for (int k = 0; k < NUM_BINS; k++)
            slot_v[k] = slot[k].valid;
    end

    assign chain_free = ((slot_v >> 1) == '0) && (!slot_v[0] || res_ready);

    // Handshake and broadcast control
    assign ctrl.shift     = res_valid && res_ready;
    assign ctrl.load      = snap_valid_reg && chain_free;
    assign smp_ready      = !snap_valid_reg || ctrl.load;
    assign ctrl.step      = smp_valid && smp_ready;
    assign ctrl.block_end = smp_data.block_end;

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (ctrl.step && smp_data.block_end)
            snap_valid_next = 1'b1;
        else if (ctrl.load)
            snap_valid_next = 1'b0;
    end

    // Bin number of the result at the head of the chain
    always_comb
    begin
        head_next = head_reg;
        if (ctrl.load)
            head_next = '0;
        else if (ctrl.shift)
            head_next = head_reg + BIN_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            head_reg       <= '0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            head_reg       <= head_next;
        end
    end

    // Row of bin cells; results hop toward cell 0
    for (genvar k = 0; k < NUM_BINS; k++)
    begin : g_cell
        if (k == NUM_BINS - 1)
        begin : g_tail
            assign nbr[k] = '0;
        end
        else
        begin : g_link
            assign nbr[k] = slot[k+1];
        end

        gmb_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .cos_coef (cos_reg[k]),
            .sin_coef (sin_reg[k]),
            .sample   (smp_data.sample),
            .nbr      (nbr[k]),
            .slot     (slot[k])
        );
    end

    // Output from the head cell
    assign res_valid           = slot[0].valid;
    assign res_data.bin_index  = head_reg;
    assign res_data.real_value = slot[0].res.real_value;
    assign res_data.imag_value = slot[0].res.imag_value;
    assign res_data.last_bin   = (head_reg == BIN_BITS'(NUM_BINS - 1));

`ifndef SYNTHESIS
    // Valid slots are always a contiguous run starting at bin 0
    a_slot_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((slot_v + 1'b1) & slot_v) == '0)
        else $error("result slots not contiguous");

    // Head bin number matches how many results remain
    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ($countones(slot_v) == NUM_BINS - int'(head_reg)))
        else $error("head bin number out of step with slot count");

    // The input stalls only while results are pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !smp_ready |-> (snap_valid_reg && (slot_v != '0)))
        else $error("input stalled with no pending results");

    // A block end leads to a snapshot on the next cycle
    a_snap_set: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && smp_data.block_end) |=> snap_valid_reg)
        else $error("block end did not capture a snapshot");

    // Loading the slots fills every bin at once
    a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (slot_v == {NUM_BINS{1'b1}}))
        else $error("slot load left bins empty");
`endif

endmodule

### sim/goertzel_bin_checker.sv
module goertzel_bin_checker
    import gmb_pkg::*;
#(
    parameter int NUM_BINS = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    smp_valid,
    input  logic                    smp_ready,
    input  gmb_in_t                 smp_data,
    input  logic                    res_valid,
    input  logic                    res_ready,
    input  gmb_out_t                res_data,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  coef_t                   cfg_data,
    output int                      fails,
    output int                      pending,
    output int                      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Wide enough to hold any product or sum exactly before clamping
    typedef logic signed [127:0] exact_t;

    // Shadow of the coefficient registers and the two delay lines per bin
    coef_t    cos_word [MAX_BINS];
    coef_t    sin_word [MAX_BINS];
    acc_t     delay_one [MAX_BINS];
    acc_t     delay_two [MAX_BINS];
    gmb_out_t bin_results_due [$];
    int       reported;

    // Q2.14 product back to sample scale, ties rounded up
    function automatic exact_t q14_round(exact_t v);
        exact_t half;
        half = exact_t'(1) <<< (COEF_FRAC - 1);
        return (v + half) >>> COEF_FRAC;
    endfunction

    function automatic acc_t acc_clamp(exact_t v);
        exact_t upper;
        exact_t lower;
        acc_t   r;
        upper = ACC_MAX;
        lower = ACC_MIN;
        if (v > upper)
            r = ACC_MAX;
        else if (v < lower)
            r = ACC_MIN;
        else
            r = v[ACC_BITS-1:0];
        return r;
    endfunction

    // Run one sample through every bin; on block end queue one result per bin
    task automatic advance_bins(input gmb_in_t item);
        exact_t   x;
        exact_t   s1;
        exact_t   s2;
        exact_t   c;
        exact_t   re;
        exact_t   im;
        gmb_out_t r;
        x = item.sample;
        for (int k = 0; k < NUM_BINS; k++)
        begin
            s1 = delay_one[k];
            s2 = delay_two[k];
            c  = cos_word[k];
            c  = c * exact_t'(2);
            delay_two[k] = delay_one[k];
            delay_one[k] = acc_clamp(q14_round(s1 * c) + x - s2);
        end
        if (item.block_end)
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                s1 = delay_one[k];
                s2 = delay_two[k];
                c  = cos_word[k];
                re = q14_round(s1 * c) - s2;
                c  = sin_word[k];
                im = q14_round(s1 * c);
                r.bin_index  = BIN_BITS'(k);
                r.real_value = acc_clamp(re);
                r.imag_value = acc_clamp(im);
                r.last_bin   = (k == NUM_BINS - 1);
                bin_results_due.push_back(r);
                delay_one[k] = '0;
                delay_two[k] = '0;
            end
        end
    endtask

    // Compare one result transfer with the oldest queued result
    task automatic check_result(input gmb_out_t got);
        gmb_out_t want;
        if (bin_results_due.size() == 0)
        begin
            fails++;
            if (reported < MAX_REPORTS)
                $display("ERROR: unexpected bin result bin=%0d re=%0d im=%0d last=%0b",
                         got.bin_index, got.real_value, got.imag_value, got.last_bin);
            reported++;
        end
        else
        begin
            want = bin_results_due.pop_front();
            if (got.bin_index !== want.bin_index || got.real_value !== want.real_value ||
                got.imag_value !== want.imag_value || got.last_bin !== want.last_bin)
            begin
                fails++;
                if (reported < MAX_REPORTS)
                begin
                    $display("ERROR: result %0d expected bin=%0d re=%0d im=%0d last=%0b",
                             checked, want.bin_index, want.real_value, want.imag_value,
                             want.last_bin);
                    $display("       got                bin=%0d re=%0d im=%0d last=%0b",
                             got.bin_index, got.real_value, got.imag_value, got.last_bin);
                end
                reported++;
            end
            checked++;
        end
    endtask

    // Watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_BINS; k++)
            begin
                cos_word[k]  = '0;
                sin_word[k]  = '0;
                delay_one[k] = '0;
                delay_two[k] = '0;
            end
            bin_results_due.delete();
            fails    = 0;
            pending  = 0;
            checked  = 0;
            reported = 0;
        end
        else
        begin
            if (res_valid && res_ready)
                check_result(res_data);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index >= CFG_SIN_BASE)
                    sin_word[cfg_index - CFG_SIN_BASE] = cfg_data;
                else
                    cos_word[cfg_index - CFG_COS_BASE] = cfg_data;
            end
            if (smp_valid && smp_ready)
                advance_bins(smp_data);
            pending = bin_results_due.size();
        end
    end

endmodule

### sim/tb_goertzel_multi_bin_top.sv
module tb_goertzel_multi_bin_top;
    import gmb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    BINS          = 4;
    localparam int    RESET_CYCLES  = 8;
    localparam int    SETTLE_CYCLES = 8;
    localparam int    CYCLE_LIMIT   = 400000;
    localparam int    SEG_ITEMS     = 52;
    localparam int    NUM_SEGMENTS  = 6;
    localparam coef_t COEF_ONE      = 16'sd16384;
    localparam coef_t COEF_NEG_ONE  = -16'sd16384;
    localparam coef_t COEF_TOP      = 16'sh7FFF;
    localparam coef_t COEF_BOTTOM   = 16'sh8000;
    localparam sample_t SMP_MAX     = 16'sh7FFF;
    localparam sample_t SMP_MIN     = 16'sh8000;

    logic                    clk;
    logic                    rst_n;
    logic                    smp_valid;
    logic                    smp_ready;
    gmb_in_t                 smp_data;
    logic                    res_valid;
    logic                    res_ready = 1'b0;
    gmb_out_t                res_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    coef_t                   cfg_data;

    int    fail_count;
    int    results_due;
    int    results_checked;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    samples_sent;
    int    blocks_sent;
    int    coef_sets;
    int    cycle_count = 0;
    coef_t cos_set [MAX_BINS];
    coef_t sin_set [MAX_BINS];

    goertzel_multi_bin_top #(
        .NUM_BINS (BINS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    goertzel_bin_checker #(
        .NUM_BINS (BINS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fail_count),
        .pending   (results_due),
        .checked   (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // One sample transfer, with random idle cycles in front
    task automatic send_sample(input sample_t value, input logic is_end);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            smp_valid <= 1'b0;
            @(negedge clk);
        end
        smp_valid <= 1'b1;
        smp_data  <= '{sample: value, block_end: is_end};
        do @(posedge clk); while (!smp_ready);
        @(negedge clk);
        samples_sent++;
        if (is_end)
            blocks_sent++;
    endtask

    // Hold off input until every queued result has left, then let the pipe settle
    task automatic drain_results();
        smp_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coef_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_coefficients();
        for (int k = 0; k < MAX_BINS; k++)
        begin
            write_reg(CFG_COS_BASE + CFG_IDX_BITS'(k), cos_set[k]);
            write_reg(CFG_SIN_BASE + CFG_IDX_BITS'(k), sin_set[k]);
        end
        cfg_valid <= 1'b0;
        coef_sets++;
    endtask

    // In-range Q2.14 word, or any 16-bit pattern raw_pct percent of the time
    function automatic coef_t pick_coef(input int raw_pct);
        if ($urandom_range(0, 99) < raw_pct)
            return coef_t'($urandom);
        return coef_t'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2, 3: return sample_t'(int'($urandom_range(0, 400)) - 200);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Whole blocks of random length until about n samples have gone in
    task automatic run_blocks(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_sample(pick_sample(), i == len - 1);
            sent += len;
            // occasionally let every result drain mid-stream
            if ($urandom_range(0, 11) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        smp_valid     = 1'b0;
        smp_data      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        samples_sent  = 0;
        blocks_sent   = 0;
        coef_sets     = 0;
        send_idle_pct = 11;
        recv_idle_pct = 85;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Coefficients still at their reset value: every imaginary part is zero
        send_sample(16'sd1234, 1'b0);
        send_sample(-16'sd4321, 1'b1);
        drain_results();

        // Unit and out-of-range coefficients on each bin
        cos_set[0] = COEF_ONE;
        cos_set[1] = COEF_NEG_ONE;
        cos_set[2] = COEF_TOP;
        cos_set[3] = COEF_BOTTOM;
        sin_set[0] = COEF_ONE;
        sin_set[1] = COEF_NEG_ONE;
        sin_set[2] = COEF_TOP;
        sin_set[3] = COEF_BOTTOM;
        load_coefficients();

        // Single-sample blocks at the sample extremes and zero
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b1);
        send_sample('0, 1'b1);

        // Near +/-2 cosine bins blow up and pin both delay lines at the rails
        for (int i = 0; i < 20; i++)
            send_sample((i < 10) ? SMP_MAX : SMP_MIN, i == 19);
        drain_results();

        // Random segments: two coefficient sets per idle pattern
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < MAX_BINS; k++)
            begin
                case (seg)
                    1:
                    begin
                        cos_set[k] = COEF_ONE;
                        sin_set[k] = COEF_NEG_ONE;
                    end
                    2:
                    begin
                        cos_set[k] = pick_coef(100);
                        sin_set[k] = pick_coef(100);
                    end
                    3:
                    begin
                        cos_set[k] = COEF_NEG_ONE;
                        sin_set[k] = COEF_ONE;
                    end
                    5:
                    begin
                        cos_set[k] = pick_coef(30);
                        sin_set[k] = pick_coef(30);
                    end
                    default:
                    begin
                        cos_set[k] = pick_coef(0);
                        sin_set[k] = pick_coef(0);
                    end
                endcase
            end
            load_coefficients();
            run_blocks(SEG_ITEMS);
            drain_results();
        end

        $display("Run covered %0d samples in %0d blocks under %0d coefficient sets,",
                 samples_sent, blocks_sent, coef_sets);
        $display("%0d bin results compared, %0d failures", results_checked, fail_count);
        if (fail_count == 0 && results_due == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
design/gmb_pkg.sv
design/gmb_cell.sv
design/goertzel_multi_bin_top.sv
sim/goertzel_bin_checker.sv
sim/tb_goertzel_multi_bin_top.sv
